[design/qr_mask_and_penalty_score_defines.svh]
// Assertion helpers shared by the scoring block.
`ifndef QR_MASK_AND_PENALTY_SCORE_DEFINES_SVH
`define QR_MASK_AND_PENALTY_SCORE_DEFINES_SVH

// Same-cycle implication, checked on every clock outside reset.
`define QRMP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define QRMP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[design/qrmp_pkg.sv]
`default_nettype none
package qrmp_pkg;
	localparam int MAX_SIDE_DEF = 177;
	localparam int MIN_SIDE = 21;
	localparam int PEN_W = 22;
	localparam logic [PEN_W-1:0] PEN_MAX = 22'h3FFFFF;
	localparam int WIN_W = 15;
	localparam int RUN_W = 8;
	localparam int POS_W = 8;
	localparam int INC_W = 9;
	localparam logic [6:0] FINDER_PAT = 7'h5D;
	localparam logic [RUN_W-1:0] RUN_MAX = 8'd255;
	localparam logic [RUN_W-1:0] RUN_PEN_START = 8'd5;
	localparam int RULE1_FIRST = 3;
	localparam int RULE2_PEN = 3;
	localparam int RULE3_PEN = 40;
	localparam int RULE4_STEP = 10;

	localparam logic CFG_GRID_SIZE = 1'b0;
	localparam logic CFG_MASK_PATTERN = 1'b1;

	typedef struct packed {
		logic [RUN_W-1:0] run;
		logic [WIN_W-1:0] hist;
	} col_ent_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic div_sq;
		logic div_num;
		logic div_step;
		logic div_fin;
	} qrmp_cmd_t;

	typedef struct packed {
		logic last;
		logic div_ge;
		logic out_blocked;
	} qrmp_stat_t;

	function automatic logic finder_like(input logic [WIN_W-1:0] w);
		logic hit;
		hit = (w[10:4] == FINDER_PAT) && ((w[14:11] == 4'd0) || (w[3:0] == 4'd0));
		return hit;
	endfunction

	// Count patterns ending at the newest module, plus the four padded
	// start positions at a line end.
	function automatic logic [2:0] finder_hits(input logic [WIN_W-1:0] w,
			input logic line_end);
		logic [2:0] cnt;
		logic [WIN_W-1:0] sh;
		cnt = {2'b0, finder_like(w)};
		for (int k = 1; k <= 4; k++) begin
			sh = w << k;
			if (line_end && finder_like(sh))
				cnt = cnt + 3'd1;
		end
		return cnt;
	endfunction

	function automatic logic [PEN_W-1:0] sat_add(input logic [PEN_W-1:0] acc,
			input logic [INC_W-1:0] inc);
		logic [PEN_W:0] s;
		s = {1'b0, acc} + {{(PEN_W+1-INC_W){1'b0}}, inc};
		return (s > {1'b0, PEN_MAX}) ? PEN_MAX : s[PEN_W-1:0];
	endfunction

	// (a*b) mod 3 for residues a, b
	function automatic logic [1:0] mul_mod3(input logic [1:0] a, input logic [1:0] b);
		logic [1:0] p;
		if (a == 2'd0 || b == 2'd0)
			p = 2'd0;
		else if (a == b)
			p = 2'd1;
		else
			p = 2'd2;
		return p;
	endfunction

	function automatic logic [1:0] inc_mod3(input logic [1:0] a);
		return (a == 2'd2) ? 2'd0 : a + 2'd1;
	endfunction
endpackage
`default_nettype wire

[design/qrmp_ctrl.sv]
`default_nettype none
module qrmp_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire qrmp_pkg::qrmp_stat_t st,
	output qrmp_pkg::qrmp_cmd_t      cmd
);
	import qrmp_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SQ,
		S_NUM,
		S_DIV,
		S_FIN
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: cmd.capture = in_valid;
			S_EXEC: cmd.exec = !st.out_blocked;
			S_SQ: cmd.div_sq = 1'b1;
			S_NUM: cmd.div_num = 1'b1;
			S_DIV: cmd.div_step = st.div_ge;
			S_FIN: cmd.div_fin = !st.out_blocked;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_EXEC;
				S_EXEC: if (!st.out_blocked) state_q <= st.last ? S_SQ : S_IDLE;
				S_SQ: state_q <= S_NUM;
				S_NUM: state_q <= S_DIV;
				S_DIV: if (!st.div_ge) state_q <= S_FIN;
				S_FIN: if (!st.out_blocked) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`include "qr_mask_and_penalty_score_defines.svh"

	`QRMP_ASSERT_NEXT(a_capture_exec, cmd.capture, state_q == S_EXEC, "capture not followed by exec")
	`QRMP_ASSERT_NEXT(a_div_ends, (state_q == S_DIV) && !st.div_ge, state_q == S_FIN, "divide did not finish")
	`QRMP_ASSERT_NOW(a_one_cmd, 1'b1, $onehot0(cmd), "more than one command at once")
endmodule
`default_nettype wire

[design/qrmp_dp.sv]
`default_nettype none
module qrmp_dp #(
	parameter int MAX_SIDE = qrmp_pkg::MAX_SIDE_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic                 cfg_index,
	input  wire logic [7:0]           cfg_wdata,
	input  wire logic                 module_color,
	input  wire logic                 is_data,
	input  wire qrmp_pkg::qrmp_cmd_t  cmd,
	output qrmp_pkg::qrmp_stat_t      st,
	input  wire logic                 out_ready,
	output logic                      out_valid,
	output logic                      masked_color,
	output logic [qrmp_pkg::PEN_W-1:0] penalty_total,
	output logic                      grid_done
);
	import qrmp_pkg::*;

	localparam int AW = $clog2(MAX_SIDE);

	logic [7:0] size_q;
	logic [2:0] mask_q;

	col_ent_t mem [MAX_SIDE];
	col_ent_t rd_q;

	logic color_q, data_q, masked_q;
	logic [POS_W-1:0] row_q, col_q;
	logic [1:0] rm3_q, cm3_q;
	logic cd3p_q;
	logic [WIN_W-1:0] row_win_q;
	logic [RUN_W-1:0] row_run_q;
	logic upleft_q;
	logic [PEN_W-1:0] pen_q;
	logic [WIN_W-1:0] dark_q;
	logic [WIN_W-1:0] nsq_q;
	logic [19:0] num_q;
	logic [3:0] quo_q;
	logic out_valid_q, out_color_q, out_done_q;
	logic [PEN_W-1:0] out_pen_q;

	logic [POS_W-1:0] n, n_m1;
	logic [1:0] p3;
	logic hit, m, left_b, up_b;
	logic row_end, col_end, last;
	logic [INC_W-1:0] inc;
	logic [RUN_W-1:0] row_run_d, col_run_d;
	logic [1:0] row_run_pen, col_run_pen;
	logic [WIN_W-1:0] row_win_d, col_hist_d;
	logic [2:0] row_f, col_f;
	logic [15:0] twice, total, diff;
	logic [15:0] sq;
	logic cfg_hit, clr, load_ok;

	assign n = (size_q < 8'(MIN_SIDE)) ? 8'(MIN_SIDE) :
		(size_q > 8'(MAX_SIDE)) ? 8'(MAX_SIDE) : size_q;
	assign n_m1 = n - 8'd1;
	assign row_end = (col_q == n_m1);
	assign col_end = (row_q == n_m1);
	assign last = row_end && col_end;

	assign p3 = mul_mod3(rm3_q, cm3_q);
	always_comb begin
		case (mask_q)
			3'd0: hit = !(row_q[0] ^ col_q[0]);
			3'd1: hit = !row_q[0];
			3'd2: hit = (cm3_q == 2'd0);
			3'd3: hit = (rm3_q == 2'd0 && cm3_q == 2'd0) ||
				(rm3_q == 2'd1 && cm3_q == 2'd2) || (rm3_q == 2'd2 && cm3_q == 2'd1);
			3'd4: hit = !(row_q[1] ^ cd3p_q);
			3'd5: hit = !(row_q[0] && col_q[0]) && (p3 == 2'd0);
			3'd6: hit = !((row_q[0] && col_q[0]) ^ (p3 == 2'd1));
			3'd7: hit = !((row_q[0] ^ col_q[0]) ^ (p3 == 2'd1));
			default: hit = 1'b0;
		endcase
	end

	assign m = color_q ^ (data_q && hit);
	assign left_b = row_win_q[0];
	assign up_b = rd_q.hist[0];

	always_comb begin
		row_run_pen = 2'd0;
		row_run_d = 8'd1;
		if (col_q != 8'd0 && left_b == m) begin
			row_run_d = (row_run_q < RUN_MAX) ? row_run_q + 8'd1 : row_run_q;
			row_run_pen = (row_run_d == RUN_PEN_START) ? 2'(RULE1_FIRST) :
				(row_run_d > RUN_PEN_START) ? 2'd1 : 2'd0;
		end
		col_run_pen = 2'd0;
		col_run_d = 8'd1;
		if (row_q != 8'd0 && up_b == m) begin
			col_run_d = (rd_q.run < RUN_MAX) ? rd_q.run + 8'd1 : rd_q.run;
			col_run_pen = (col_run_d == RUN_PEN_START) ? 2'(RULE1_FIRST) :
				(col_run_d > RUN_PEN_START) ? 2'd1 : 2'd0;
		end
	end

	assign row_win_d = (col_q == 8'd0) ? {{(WIN_W-1){1'b0}}, m} : {row_win_q[WIN_W-2:0], m};
	assign col_hist_d = (row_q == 8'd0) ? {{(WIN_W-1){1'b0}}, m} : {rd_q.hist[WIN_W-2:0], m};
	assign row_f = finder_hits(row_win_d, row_end);
	assign col_f = finder_hits(col_hist_d, col_end);

	always_comb begin
		inc = 9'(row_run_pen) + 9'(col_run_pen) + 9'((row_f + col_f) * RULE3_PEN);
		if (row_q != 8'd0 && col_q != 8'd0 && left_b == m && up_b == m && upleft_q == m)
			inc = inc + 9'(RULE2_PEN);
	end

	assign twice = {dark_q, 1'b0};
	assign total = {1'b0, nsq_q};
	assign diff = (twice > total) ? twice - total : total - twice;
	assign sq = n * n;

	assign cfg_hit = cfg_we && (cfg_index == CFG_GRID_SIZE || cfg_index == CFG_MASK_PATTERN);
	assign clr = cfg_hit || cmd.div_fin;
	assign load_ok = !out_valid_q || out_ready;

	assign st.last = last;
	assign st.div_ge = (num_q >= {5'd0, nsq_q});
	assign st.out_blocked = !load_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= 8'(MIN_SIDE);
			mask_q <= 3'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GRID_SIZE: size_q <= cfg_wdata;
				CFG_MASK_PATTERN: mask_q <= cfg_wdata[2:0];
				default: size_q <= size_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			color_q <= module_color;
			data_q <= is_data;
			rd_q <= mem[col_q[AW-1:0]];
		end
		if (cmd.exec) begin
			mem[col_q[AW-1:0]] <= '{run: col_run_d, hist: col_hist_d};
			masked_q <= m;
			upleft_q <= up_b;
		end
		if (cmd.div_sq)
			nsq_q <= sq[WIN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			rm3_q <= '0;
			cm3_q <= '0;
			cd3p_q <= 1'b0;
			row_win_q <= '0;
			row_run_q <= '0;
			pen_q <= '0;
			dark_q <= '0;
			num_q <= '0;
			quo_q <= '0;
		end else if (clr) begin
			row_q <= '0;
			col_q <= '0;
			rm3_q <= '0;
			cm3_q <= '0;
			cd3p_q <= 1'b0;
			row_win_q <= '0;
			row_run_q <= '0;
			pen_q <= '0;
			dark_q <= '0;
		end else begin
			if (cmd.exec) begin
				row_win_q <= row_win_d;
				row_run_q <= row_run_d;
				pen_q <= sat_add(pen_q, inc);
				if (m)
					dark_q <= dark_q + 15'd1;
				if (!last) begin
					if (row_end) begin
						col_q <= '0;
						cm3_q <= '0;
						cd3p_q <= 1'b0;
						row_q <= row_q + 8'd1;
						rm3_q <= inc_mod3(rm3_q);
					end else begin
						col_q <= col_q + 8'd1;
						cm3_q <= inc_mod3(cm3_q);
						if (cm3_q == 2'd2)
							cd3p_q <= !cd3p_q;
					end
				end
			end
			if (cmd.div_num) begin
				num_q <= {1'b0, diff, 3'b0} + {3'b0, diff, 1'b0};
				quo_q <= '0;
			end
			if (cmd.div_step) begin
				num_q <= num_q - {5'd0, nsq_q};
				quo_q <= quo_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_ok) begin
			out_valid_q <= (cmd.exec && !last) || cmd.div_fin;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && !last && load_ok) begin
			out_color_q <= m;
			out_pen_q <= '0;
			out_done_q <= 1'b0;
		end else if (cmd.div_fin) begin
			out_color_q <= masked_q;
			out_pen_q <= sat_add(pen_q, 9'(quo_q * RULE4_STEP));
			out_done_q <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign masked_color = out_color_q;
	assign penalty_total = out_pen_q;
	assign grid_done = out_done_q;

	`include "qr_mask_and_penalty_score_defines.svh"

	`QRMP_ASSERT_NOW(a_pos_range, 1'b1, (row_q < n) && (col_q < n), "position outside grid")
	`QRMP_ASSERT_NOW(a_quo_range, 1'b1, quo_q <= 4'd10, "balance quotient above ten")
	`QRMP_ASSERT_NEXT(a_fin_clears, cmd.div_fin, (row_q == 8'd0) && (col_q == 8'd0) && (pen_q == '0), "grid state not cleared")
endmodule
`default_nettype wire

[design/qr_mask_and_penalty_score.sv]
// Channel   Direction  Signals                                   Handshake
// input     in         module_color, is_data                     in_valid / in_ready
// output    out        masked_color, penalty_total, grid_done    out_valid / out_ready
// config    in         cfg_index, cfg_wdata                      cfg_we, no wait
//
// Each module is captured, reading its column's history and run length from
// the column memory, then scored and written back. The last module of a grid
// also runs the dark-balance rule: square, numerator, up to 10 divide steps,
// final compare and load. Reset is asynchronous and needs no clearing pass: a
// column entry is always written in row 0 before it is used. A full output
// register holds the control in its scoring or final load state until the
// item is taken.
`default_nettype none
module qr_mask_and_penalty_score #(
	parameter int MAX_SIDE = qrmp_pkg::MAX_SIDE_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic                  cfg_index,
	input  wire logic [7:0]            cfg_wdata,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  module_color,
	input  wire logic                  is_data,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       masked_color,
	output logic [qrmp_pkg::PEN_W-1:0] penalty_total,
	output logic                       grid_done
);
	import qrmp_pkg::*;

	// command and status between sequencer and datapath
	qrmp_cmd_t cmd;
	qrmp_stat_t st;

	// sequencer: capture, score, then the balance divide at grid end
	qrmp_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.st(st),
		.cmd(cmd)
	);

	// datapath: mask, row window, column memory, penalty sum, output register
	qrmp_dp #(
		.MAX_SIDE(MAX_SIDE)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.module_color(module_color),
		.is_data(is_data),
		.cmd(cmd),
		.st(st),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.masked_color(masked_color),
		.penalty_total(penalty_total),
		.grid_done(grid_done)
	);
endmodule
`default_nettype wire

[test/qr_mask_and_penalty_score_tb.sv]
`timescale 1ns / 1ps

module qr_mask_and_penalty_score_tb;
	import qrmp_pkg::*;

	localparam int SIDE_LIMIT = 177;

	typedef struct {
		bit        masked;
		bit [21:0] total;
		bit        done;
	} module_result_t;

	// Running score of the masked grid plus the queue of masked modules owed.
	class mask_score_tracker;
		bit [7:0]       size_reg;
		bit [2:0]       mask_reg;
		bit [14:0]      col_hist [SIDE_LIMIT];
		bit [7:0]       col_run [SIDE_LIMIT];
		bit [14:0]      row_win;
		bit [7:0]       row_run;
		int unsigned    row_pos;
		int unsigned    col_pos;
		int unsigned    penalty;
		bit [14:0]      dark;
		module_result_t pending_modules[$];
		int             errors;

		function void clear_grid();
			foreach (col_hist[i]) begin
				col_hist[i] = '0;
				col_run[i] = '0;
			end
			row_win = '0;
			row_run = '0;
			row_pos = 0;
			col_pos = 0;
			penalty = 0;
			dark = '0;
		endfunction

		function void reset_regs();
			size_reg = 8'd21;
			mask_reg = 3'd0;
			errors = 0;
			clear_grid();
		endfunction

		function void write_reg(bit idx, bit [7:0] val);
			if (idx == CFG_GRID_SIZE)
				size_reg = val;
			else
				mask_reg = val[2:0];
			clear_grid();
		endfunction

		function void add(int unsigned v);
			penalty = (penalty + v > PEN_MAX) ? PEN_MAX : penalty + v;
		endfunction

		function bit mask_on(int unsigned r, int unsigned c);
			int unsigned p;
			p = r * c;
			case (mask_reg)
				3'd0: return (r + c) % 2 == 0;
				3'd1: return r % 2 == 0;
				3'd2: return c % 3 == 0;
				3'd3: return (r + c) % 3 == 0;
				3'd4: return (r / 2 + c / 3) % 2 == 0;
				3'd5: return (p % 2 + p % 3) == 0;
				3'd6: return ((p % 2 + p % 3) % 2) == 0;
				default: return (((r + c) % 2 + p % 3) % 2) == 0;
			endcase
		endfunction

		function bit finder_at(bit [14:0] w);
			return w[10:4] == FINDER_PAT && (w[14:11] == 4'd0 || w[3:0] == 4'd0);
		endfunction

		// Pattern ending at the newest module; at a line end, the padded tails too.
		function void score_finder(bit [14:0] w, bit line_end);
			bit [14:0] sh;
			if (finder_at(w))
				add(RULE3_PEN);
			if (line_end) begin
				for (int k = 1; k <= 4; k++) begin
					sh = w << k;
					if (finder_at(sh))
						add(RULE3_PEN);
				end
			end
		endfunction

		function bit [7:0] extend_run(bit [7:0] run, bit same);
			if (!same)
				return 8'd1;
			if (run < 8'd255)
				run++;
			if (run == 8'd5)
				add(RULE1_FIRST);
			else if (run > 8'd5)
				add(1);
			return run;
		endfunction

		function void note_module(bit color, bit data);
			int unsigned    n, r, c, sq, twice, diff;
			bit             m;
			module_result_t res;
			n = (size_reg < 21) ? 21 : (size_reg > SIDE_LIMIT) ? SIDE_LIMIT : size_reg;
			if (row_pos >= n || col_pos >= n)
				clear_grid();
			r = row_pos;
			c = col_pos;
			m = color ^ (data && mask_on(r, c));
			// 2x2 block with this module at its lower right
			if (r > 0 && c > 0 && row_win[0] == m && col_hist[c][0] == m
					&& col_hist[c-1][1] == m)
				add(RULE2_PEN);
			row_run = (c == 0) ? 8'd1 : extend_run(row_run, row_win[0] == m);
			col_run[c] = (r == 0) ? 8'd1 : extend_run(col_run[c], col_hist[c][0] == m);
			row_win = (c == 0) ? {14'd0, m} : {row_win[13:0], m};
			score_finder(row_win, c == n - 1);
			col_hist[c] = (r == 0) ? {14'd0, m} : {col_hist[c][13:0], m};
			score_finder(col_hist[c], r == n - 1);
			if (m)
				dark++;
			res.masked = m;
			res.total = '0;
			res.done = (r == n - 1) && (c == n - 1);
			if (res.done) begin
				sq = n * n;
				twice = dark * 2;
				diff = (twice > sq) ? twice - sq : sq - twice;
				add((diff * 10 / sq) * RULE4_STEP);
				res.total = 22'(penalty);
				clear_grid();
			end else if (c == n - 1) begin
				col_pos = 0;
				row_pos = r + 1;
			end else begin
				col_pos = c + 1;
			end
			pending_modules.push_back(res);
		endfunction

		function void check_module(bit m, bit [21:0] total, bit done);
			module_result_t exp_res;
			if (pending_modules.size() == 0) begin
				$error("unexpected module out: masked_color %0d", m);
				errors++;
				return;
			end
			exp_res = pending_modules.pop_front();
			if (m !== exp_res.masked) begin
				$error("masked_color expected %0d actual %0d", exp_res.masked, m);
				errors++;
			end
			if (total !== exp_res.total) begin
				$error("penalty_total expected %0d actual %0d", exp_res.total, total);
				errors++;
			end
			if (done !== exp_res.done) begin
				$error("grid_done expected %0d actual %0d", exp_res.done, done);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [7:0]  cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic        module_color;
	logic        is_data;
	logic        out_valid;
	logic        out_ready;
	logic        masked_color;
	logic [21:0] penalty_total;
	logic        grid_done;

	mask_score_tracker tracker;
	int                idle_max;

	// Color source state: style of the current stretch and its position.
	int  color_style;
	int  pat_idx;
	bit  last_color;

	qr_mask_and_penalty_score i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.module_color (module_color),
		.is_data      (is_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.masked_color (masked_color),
		.penalty_total(penalty_total),
		.grid_done    (grid_done)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Hang guard: the slowest legal run is far below this.
	initial begin
		#6000000;
		$display("FAIL qr_mask_and_penalty_score");
		$finish;
	end

	// Drive one module: optional gap, then hold valid until the block takes it.
	task automatic send_module(bit color, bit data);
		int gap;
		gap = $urandom_range(idle_max, 0);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		module_color <= color;
		is_data <= data;
		do @(posedge clk); while (!in_ready);
		tracker.note_module(color, data);
	endtask

	// Drop valid and wait out every owed module plus the end-of-grid divide.
	task automatic drain();
		in_valid <= 1'b0;
		while (tracker.pending_modules.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(bit idx, bit [7:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.write_reg(idx, val);
	endtask

	// Pick a color: pure noise, sticky runs, finder-like stream, or one flat color.
	function automatic bit next_color();
		bit [14:0] finder_line;
		finder_line = 15'b000010111010000;
		case (color_style)
			0: last_color = 1'($urandom_range(1, 0));
			1: if ($urandom_range(7, 0) == 0) last_color = !last_color;
			2: begin
				last_color = finder_line[14 - pat_idx];
				if ($urandom_range(31, 0) == 0)
					last_color = !last_color;
				pat_idx = (pat_idx == 14) ? 0 : pat_idx + 1;
			end
			default: ;
		endcase
		return last_color;
	endfunction

	task automatic send_run(int count);
		bit c;
		for (int i = 0; i < count; i++) begin
			if (i % 97 == 0) begin
				color_style = $urandom_range(3, 0);
				pat_idx = $urandom_range(14, 0);
				last_color = 1'($urandom_range(1, 0));
			end
			c = next_color();
			// Keep structured colors mostly unmasked so the patterns survive.
			send_module(c, (color_style == 0) ? 1'($urandom_range(1, 0))
				: ($urandom_range(7, 0) == 0));
			// Hold off once until the block has emptied.
			if (i == 100)
				drain();
		end
	endtask

	// Result side: random stall before each module, then take it.
	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(idle_max, 0);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			tracker.check_module(masked_color, penalty_total, grid_done);
		end
	end

	initial begin
		bit [7:0]  sizes [4];
		bit [14:0] finder_line;
		int        n;
		tracker = new();
		tracker.reset_regs();
		idle_max = 4;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		module_color = 1'b0;
		is_data = 1'b0;
		finder_line = 15'b000010111010000;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every color / data combination, then a light run, a dark run
		// and a finder pattern with light on both sides, all under reset settings.
		for (int i = 0; i < 4; i++)
			send_module(i[0], i[1]);
		for (int i = 0; i < 6; i++)
			send_module(1'b0, 1'b0);
		for (int i = 0; i < 6; i++)
			send_module(1'b1, 1'b0);
		for (int i = 0; i < 15; i++)
			send_module(finder_line[14 - i], 1'b0);
		// Finish the first 21x21 grid.
		send_run(441 - 31);

		// Sweep all masks; masks 0 and 4 run a whole grid, the others stop
		// early so a register write lands in mid-grid.
		sizes = '{8'd0, 8'd25, 8'd22, 8'd29};
		for (int p = 0; p < 8; p++) begin
			idle_max = (p % 3 == 0) ? 0 : 4;
			if (p % 2 == 0)
				write_reg(CFG_GRID_SIZE, sizes[p / 2]);
			write_reg(CFG_MASK_PATTERN, {5'($urandom_range(31, 0)), p[2:0]});
			n = (sizes[p / 2] < 21) ? 21 : sizes[p / 2];
			send_run((p % 4 == 0) ? n * n : 50);
		end

		// Largest grid, requested above the legal range: its whole first row
		// and part of the next.
		idle_max = 1;
		write_reg(CFG_GRID_SIZE, 8'd255);
		write_reg(CFG_MASK_PATTERN, 8'($urandom_range(255, 0)));
		send_run(200);

		drain();
		repeat (30) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending_modules.size() == 0)
			$display("PASS qr_mask_and_penalty_score");
		else
			$display("FAIL qr_mask_and_penalty_score");
		$finish;
	end
endmodule

[filelist.f]
+incdir+design
design/qrmp_pkg.sv
design/qrmp_ctrl.sv
design/qrmp_dp.sv
design/qr_mask_and_penalty_score.sv
test/qr_mask_and_penalty_score_tb.sv
